/* hw/rtl/trfs_pkg.sv */
// ----------------------------------------------------------------------------
// trfs_pkg
// Shared types, sizes and controller codes for the rectangle fill sequencer.
// ----------------------------------------------------------------------------
package trfs_pkg;

  // largest screen dimension handled, in pixels
  localparam int MAX_DIM    = 256;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int COORD_W    = $clog2(MAX_DIM);
  localparam int OFFSET_W   = 8;
  localparam int BOUND_W    = ((COORD_W > OFFSET_W) ? COORD_W : OFFSET_W) + 1;
  localparam int PIX_W      = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int REG_DIM_W  = 9;
  localparam int ROT_W      = 2;
  localparam int FIELD_W    = 10;
  localparam int CMP_W      = ((DIM_W > FIELD_W) ? DIM_W : FIELD_W) + 1;
  localparam int COLOR_W    = 16;
  localparam int BYTE_W     = 8;
  localparam int CMD_W      = 2;
  localparam int HDR_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILL  = 2'd0,
    CMD_IMAGE = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET   = 3'd4;

  localparam logic [REG_DIM_W-1:0] PANEL_WIDTH_RST  = 9'd128;
  localparam logic [REG_DIM_W-1:0] PANEL_HEIGHT_RST = 9'd160;

  // controller command bytes
  localparam logic [BYTE_W-1:0] OP_COLSET = 8'h2A;
  localparam logic [BYTE_W-1:0] OP_ROWSET = 8'h2B;
  localparam logic [BYTE_W-1:0] OP_MEMWR  = 8'h2C;

  // header sequence positions
  localparam logic [HDR_W-1:0] HDR_COLSET = 4'd0;
  localparam logic [HDR_W-1:0] HDR_ROWSET = 4'd5;
  localparam logic [HDR_W-1:0] HDR_MEMWR  = 4'd10;
  localparam logic [HDR_W-1:0] HDR_DONE   = 4'd11;

  typedef struct packed {
    logic               ok;
    logic [BOUND_W-1:0] col_start;
    logic [BOUND_W-1:0] row_start;
    logic [BOUND_W-1:0] col_end;
    logic [BOUND_W-1:0] row_end;
    logic [PIX_W-1:0]   pixels;
  } win_t;

  function automatic logic [DIM_W-1:0] cap_dim(input logic [REG_DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (32'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/trfs_if.sv */
// ----------------------------------------------------------------------------
// trfs channel interfaces
// Valid/ready channels for start and step items and for controller bytes.
// ----------------------------------------------------------------------------
interface trfs_in_if;
  logic                             valid;
  logic                             ready;
  logic [trfs_pkg::CMD_W-1:0]       command;
  logic [trfs_pkg::FIELD_W-1:0]     x_origin;
  logic [trfs_pkg::FIELD_W-1:0]     y_origin;
  logic [trfs_pkg::FIELD_W-1:0]     rect_width;
  logic [trfs_pkg::FIELD_W-1:0]     rect_height;
  logic [trfs_pkg::COLOR_W-1:0]     color;

  modport source (
    output valid, command, x_origin, y_origin, rect_width, rect_height, color,
    input  ready
  );
  modport sink (
    input  valid, command, x_origin, y_origin, rect_width, rect_height, color,
    output ready
  );
endinterface

interface trfs_out_if;
  logic                        valid;
  logic                        ready;
  logic [trfs_pkg::BYTE_W-1:0] out_byte;
  logic                        is_data;
  logic                        first;
  logic                        last;

  modport source (
    output valid, out_byte, is_data, first, last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, is_data, first, last,
    output ready
  );
endinterface

/* hw/rtl/trfs_start_chk.sv */
// ----------------------------------------------------------------------------
// trfs_start_chk
// Checks a start item against the screen, clips fills and works out the
// address window with offsets and the pixel count.
// ----------------------------------------------------------------------------
module trfs_start_chk (
  input  logic [trfs_pkg::FIELD_W-1:0]  x_origin,
  input  logic [trfs_pkg::FIELD_W-1:0]  y_origin,
  input  logic [trfs_pkg::FIELD_W-1:0]  rect_width,
  input  logic [trfs_pkg::FIELD_W-1:0]  rect_height,
  input  logic                          is_image,
  input  logic [trfs_pkg::DIM_W-1:0]    screen_w,
  input  logic [trfs_pkg::DIM_W-1:0]    screen_h,
  input  logic [trfs_pkg::OFFSET_W-1:0] col_offset,
  input  logic [trfs_pkg::OFFSET_W-1:0] row_offset,
  output trfs_pkg::win_t                win
);

  logic [trfs_pkg::CMP_W-1:0]     x_c, y_c, w_c, h_c, sw_c, sh_c;
  logic [trfs_pkg::CMP_W-1:0]     rem_w, rem_h;
  logic                           x_off, y_off, w_over, h_over, empty;
  logic [trfs_pkg::DIM_W-1:0]     w_eff, h_eff;
  logic [trfs_pkg::COORD_W-1:0]   x_pos, y_pos, x_last, y_last;
  logic [2*trfs_pkg::DIM_W-1:0]   area;

  assign x_c  = trfs_pkg::CMP_W'(x_origin);
  assign y_c  = trfs_pkg::CMP_W'(y_origin);
  assign w_c  = trfs_pkg::CMP_W'(rect_width);
  assign h_c  = trfs_pkg::CMP_W'(rect_height);
  assign sw_c = trfs_pkg::CMP_W'(screen_w);
  assign sh_c = trfs_pkg::CMP_W'(screen_h);

  assign x_off = (x_c >= sw_c);
  assign y_off = (y_c >= sh_c);
  // room left to the screen edge, meaningful only when the origin is on screen
  assign rem_w = sw_c - x_c;
  assign rem_h = sh_c - y_c;
  assign w_over = (w_c > rem_w);
  assign h_over = (h_c > rem_h);
  assign empty  = (rect_width == '0) || (rect_height == '0);

  assign w_eff = w_over ? rem_w[trfs_pkg::DIM_W-1:0] : w_c[trfs_pkg::DIM_W-1:0];
  assign h_eff = h_over ? rem_h[trfs_pkg::DIM_W-1:0] : h_c[trfs_pkg::DIM_W-1:0];

  assign x_pos  = x_origin[trfs_pkg::COORD_W-1:0];
  assign y_pos  = y_origin[trfs_pkg::COORD_W-1:0];
  // wraps correctly for a full-width window
  assign x_last = x_pos + trfs_pkg::COORD_W'(w_eff) - trfs_pkg::COORD_W'(1);
  assign y_last = y_pos + trfs_pkg::COORD_W'(h_eff) - trfs_pkg::COORD_W'(1);

  assign area = w_eff * h_eff;

  assign win.ok = !empty && !x_off && !y_off && !(is_image && (w_over || h_over));
  assign win.col_start = trfs_pkg::BOUND_W'(x_pos) + trfs_pkg::BOUND_W'(col_offset);
  assign win.row_start = trfs_pkg::BOUND_W'(y_pos) + trfs_pkg::BOUND_W'(row_offset);
  assign win.col_end   = trfs_pkg::BOUND_W'(x_last) + trfs_pkg::BOUND_W'(col_offset);
  assign win.row_end   = trfs_pkg::BOUND_W'(y_last) + trfs_pkg::BOUND_W'(row_offset);
  assign win.pixels    = area[trfs_pkg::PIX_W-1:0];

endmodule

/* hw/rtl/tft_rect_fill_byte_sequencer.sv */
// ----------------------------------------------------------------------------
// tft_rect_fill_byte_sequencer
// Turns fill/image start items and step items into controller bytes:
// window header, memory-write command, then pixel bytes.
// ----------------------------------------------------------------------------
//  channel    | dir | handshake     | payload
//  items_in   | in  | valid/ready   | command, x_origin, y_origin, rect_width,
//             |     |               | rect_height, color
//  bytes_out  | out | valid/ready   | out_byte, is_data, first, last
//  cfg        | in  | cfg_we        | cfg_index, cfg_data
//
//  one item per cycle while items_in.ready is high; a step item's byte
//  appears in the output register in the cycle after it is accepted
//  items_in.ready is low only while the output register holds an untaken byte
//  starts and idle steps give no byte and never hold up the input
//  rst is synchronous: sequencer idle, configuration at its reset values
// ----------------------------------------------------------------------------
module tft_rect_fill_byte_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [trfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trfs_pkg::CFG_DATA_W-1:0] cfg_data,
  trfs_in_if.sink                         items_in,
  trfs_out_if.source                      bytes_out
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_FILL,
    MODE_IMAGE
  } mode_t;

  // configuration
  logic [trfs_pkg::REG_DIM_W-1:0] panel_width, panel_height;
  logic [trfs_pkg::ROT_W-1:0]     rotation;
  logic [trfs_pkg::OFFSET_W-1:0]  col_offset, row_offset;

  // sequencer state
  mode_t                          mode, mode_next;
  logic [trfs_pkg::HDR_W-1:0]     header_step, header_step_next;
  logic [trfs_pkg::PIX_W-1:0]     pixels_left, pixels_left_next;
  logic                           low_half_next, low_half_next_next;
  logic [trfs_pkg::COLOR_W-1:0]   pixel_hold, pixel_hold_next;
  logic [trfs_pkg::BOUND_W-1:0]   col_start, row_start, col_end, row_end;

  // output register
  logic                           out_valid;
  logic [trfs_pkg::BYTE_W-1:0]    out_byte;
  logic                           out_is_data, out_first, out_last;

  logic                           in_fire, start_load;
  logic                           res_emit, res_data, res_first, res_last;
  logic [trfs_pkg::BYTE_W-1:0]    res_byte;
  logic [trfs_pkg::DIM_W-1:0]     screen_w, screen_h;
  logic [trfs_pkg::HDR_W-1:0]     hdr_k;
  logic [trfs_pkg::BOUND_W-1:0]   bound_sel;
  logic [2*trfs_pkg::BYTE_W-1:0]  bound_word;
  logic [trfs_pkg::PIX_W-1:0]     pixels_dec;
  trfs_pkg::win_t                 win;

  assign items_in.ready = !out_valid || bytes_out.ready;
  assign in_fire        = items_in.valid && items_in.ready;

  assign bytes_out.valid    = out_valid;
  assign bytes_out.out_byte = out_byte;
  assign bytes_out.is_data  = out_is_data;
  assign bytes_out.first    = out_first;
  assign bytes_out.last     = out_last;

  // odd rotation swaps the screen axes
  assign screen_w = trfs_pkg::cap_dim(rotation[0] ? panel_height : panel_width);
  assign screen_h = trfs_pkg::cap_dim(rotation[0] ? panel_width : panel_height);

  trfs_start_chk u_start_chk (
    .x_origin    (items_in.x_origin),
    .y_origin    (items_in.y_origin),
    .rect_width  (items_in.rect_width),
    .rect_height (items_in.rect_height),
    .is_image    (items_in.command == trfs_pkg::CMD_IMAGE),
    .screen_w    (screen_w),
    .screen_h    (screen_h),
    .col_offset  (col_offset),
    .row_offset  (row_offset),
    .win         (win)
  );

  // window byte selection within the header
  always_comb begin
    if (header_step < trfs_pkg::HDR_ROWSET) begin
      hdr_k     = header_step - (trfs_pkg::HDR_COLSET + trfs_pkg::HDR_W'(1));
      bound_sel = hdr_k[1] ? col_end : col_start;
    end else begin
      hdr_k     = header_step - (trfs_pkg::HDR_ROWSET + trfs_pkg::HDR_W'(1));
      bound_sel = hdr_k[1] ? row_end : row_start;
    end
    bound_word = (2*trfs_pkg::BYTE_W)'(bound_sel);
  end

  assign pixels_dec = (pixels_left != '0) ? pixels_left - trfs_pkg::PIX_W'(1)
                                          : pixels_left;

  always_comb begin
    mode_next          = mode;
    header_step_next   = header_step;
    pixels_left_next   = pixels_left;
    low_half_next_next = low_half_next;
    pixel_hold_next    = pixel_hold;
    start_load         = 1'b0;
    res_emit           = 1'b0;
    res_byte           = '0;
    res_data           = 1'b1;
    res_first          = 1'b0;
    res_last           = 1'b0;
    if (in_fire) begin
      case (items_in.command)
        trfs_pkg::CMD_FILL, trfs_pkg::CMD_IMAGE: begin
          if (mode == MODE_IDLE && win.ok) begin
            start_load         = 1'b1;
            header_step_next   = trfs_pkg::HDR_COLSET;
            pixels_left_next   = win.pixels;
            low_half_next_next = 1'b0;
            if (items_in.command == trfs_pkg::CMD_IMAGE) begin
              mode_next       = MODE_IMAGE;
              pixel_hold_next = '0;
            end else begin
              mode_next       = MODE_FILL;
              pixel_hold_next = items_in.color;
            end
          end
        end
        trfs_pkg::CMD_STEP: begin
          if (mode != MODE_IDLE) begin
            res_emit = 1'b1;
            if (header_step != trfs_pkg::HDR_DONE) begin
              header_step_next = header_step + trfs_pkg::HDR_W'(1);
              if (header_step == trfs_pkg::HDR_COLSET) begin
                res_byte  = trfs_pkg::OP_COLSET;
                res_data  = 1'b0;
                res_first = 1'b1;
              end else if (header_step == trfs_pkg::HDR_ROWSET) begin
                res_byte = trfs_pkg::OP_ROWSET;
                res_data = 1'b0;
              end else if (header_step == trfs_pkg::HDR_MEMWR) begin
                res_byte = trfs_pkg::OP_MEMWR;
                res_data = 1'b0;
              end else begin
                res_byte = hdr_k[0] ? bound_word[trfs_pkg::BYTE_W-1:0]
                                    : bound_word[2*trfs_pkg::BYTE_W-1:trfs_pkg::BYTE_W];
              end
            end else if (!low_half_next) begin
              // image pixels arrive with the high-byte step
              if (mode == MODE_IMAGE) begin
                pixel_hold_next = items_in.color;
              end
              res_byte           = pixel_hold_next[2*trfs_pkg::BYTE_W-1:trfs_pkg::BYTE_W];
              low_half_next_next = 1'b1;
            end else begin
              res_byte           = pixel_hold[trfs_pkg::BYTE_W-1:0];
              low_half_next_next = 1'b0;
              pixels_left_next   = pixels_dec;
              if (pixels_dec == '0) begin
                res_last         = 1'b1;
                mode_next        = MODE_IDLE;
                header_step_next = trfs_pkg::HDR_COLSET;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width   <= trfs_pkg::PANEL_WIDTH_RST;
      panel_height  <= trfs_pkg::PANEL_HEIGHT_RST;
      rotation      <= '0;
      col_offset    <= '0;
      row_offset    <= '0;
      mode          <= MODE_IDLE;
      header_step   <= trfs_pkg::HDR_COLSET;
      pixels_left   <= '0;
      low_half_next <= 1'b0;
      pixel_hold    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          trfs_pkg::CFG_PANEL_WIDTH:  panel_width  <= cfg_data[trfs_pkg::REG_DIM_W-1:0];
          trfs_pkg::CFG_PANEL_HEIGHT: panel_height <= cfg_data[trfs_pkg::REG_DIM_W-1:0];
          trfs_pkg::CFG_ROTATION:     rotation     <= cfg_data[trfs_pkg::ROT_W-1:0];
          trfs_pkg::CFG_COL_OFFSET:   col_offset   <= cfg_data[trfs_pkg::OFFSET_W-1:0];
          trfs_pkg::CFG_ROW_OFFSET:   row_offset   <= cfg_data[trfs_pkg::OFFSET_W-1:0];
          default: begin
          end
        endcase
      end
      mode          <= mode_next;
      header_step   <= header_step_next;
      pixels_left   <= pixels_left_next;
      low_half_next <= low_half_next_next;
      pixel_hold    <= pixel_hold_next;
      if (in_fire && res_emit) begin
        out_valid <= 1'b1;
      end else if (bytes_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // window bounds and output payload carry no reset
  always_ff @(posedge clk) begin
    if (start_load) begin
      col_start <= win.col_start;
      row_start <= win.row_start;
      col_end   <= win.col_end;
      row_end   <= win.row_end;
    end
    if (in_fire && res_emit) begin
      out_byte    <= res_byte;
      out_is_data <= res_data;
      out_first   <= res_first;
      out_last    <= res_last;
    end
  end

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_IDLE |-> header_step == trfs_pkg::HDR_COLSET && !low_half_next)
    else $error("idle sequencer left with header or pixel phase state");

  a_hdr_range: assert property (@(posedge clk) disable iff (rst)
    header_step <= trfs_pkg::HDR_DONE)
    else $error("header step past the pixel phase");

  a_low_in_pixels: assert property (@(posedge clk) disable iff (rst)
    low_half_next |-> header_step == trfs_pkg::HDR_DONE)
    else $error("low pixel byte pending during the header");

  a_active_has_pixels: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_IDLE |-> pixels_left != '0)
    else $error("transfer running with no pixels left");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_emit && res_last) |=> mode == MODE_IDLE && out_valid && out_last)
    else $error("final pixel byte did not end the transfer");
`endif

endmodule
